// ===== hdl/lav_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lav_pkg;

   localparam int SQRT_STAGES = 16;
   localparam int SQRT_STEPS  = 2;
   localparam int DIV_STAGES  = 6;
   localparam int DIV_STEPS   = 3;
   localparam int Q_TOP_BIT   = 16;

   localparam logic [1:0] COL_RIGHT = 2'd0;
   localparam logic [1:0] COL_UP    = 2'd1;
   localparam logic [1:0] COL_FWD   = 2'd2;
   localparam logic [1:0] COL_LAST  = 2'd3;

   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

   typedef logic [2:0][31:0] vec32_type;
   typedef logic [2:0][63:0] vec64_type;
   typedef logic [2:0][32:0] vec33_type;
   typedef logic [2:0][17:0] axis_type;
   typedef axis_type [2:0]   axes_type;

   typedef struct packed {
      vec32_type eye;
      vec32_type up_hint;
      axis_type  fwd;
      axis_type  right;
      logic      degen;
   } ctx_type;

   typedef struct packed {
      logic signed [31:0] eye_x;
      logic signed [31:0] eye_y;
      logic signed [31:0] eye_z;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [31:0] target_z;
      logic signed [31:0] up_hint_x;
      logic signed [31:0] up_hint_y;
      logic signed [31:0] up_hint_z;
   } req_type;

   typedef struct packed {
      logic [1:0]         column_index;
      logic signed [31:0] entry_row0;
      logic signed [31:0] entry_row1;
      logic signed [31:0] entry_row2;
      logic signed [31:0] entry_row3;
      logic               degenerate;
      logic               last_column;
   } rsp_type;

endpackage
`default_nettype wire

// ===== hdl/lav_norm.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lav_norm (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  lav_pkg::vec64_type in_vec,
   input  lav_pkg::ctx_type   in_ctx,
   output logic               out_valid,
   output lav_pkg::axis_type  out_axis,
   output logic               out_zero,
   output lav_pkg::ctx_type   out_ctx
);

   typedef struct packed {
      logic [2:0][29:0] sm;
      logic [2:0]       neg;
      logic             zero;
      logic [63:0]      v;
      logic [63:0]      res;
   } sqrt_type;

   typedef struct packed {
      logic [2:0][48:0] rem;
      logic [2:0][16:0] q;
      logic [30:0]      len;
      logic [2:0]       neg;
      logic             zero;
   } div_type;

   // magnitudes
   logic               s1_valid_ff;
   logic [2:0][63:0]   s1_mag_ff;
   logic [2:0]         s1_neg_ff;
   lav_pkg::ctx_type   s1_ctx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
      for (int i = 0; i < 3; i++) begin
         s1_mag_ff[i] <= in_vec[i][63] ? (64'd0 - in_vec[i]) : in_vec[i];
         s1_neg_ff[i] <= in_vec[i][63];
      end
      s1_ctx_ff <= in_ctx;
   end

   // largest magnitude
   logic               s2_valid_ff;
   logic [63:0]        s2_mx_ff;
   logic [63:0]        s2_mx_in;
   logic [2:0][63:0]   s2_mag_ff;
   logic [2:0]         s2_neg_ff;
   lav_pkg::ctx_type   s2_ctx_ff;

   always_comb begin
      s2_mx_in = s1_mag_ff[0];
      if (s1_mag_ff[1] > s2_mx_in) begin
         s2_mx_in = s1_mag_ff[1];
      end
      if (s1_mag_ff[2] > s2_mx_in) begin
         s2_mx_in = s1_mag_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_mx_ff  <= s2_mx_in;
      s2_mag_ff <= s1_mag_ff;
      s2_neg_ff <= s1_neg_ff;
      s2_ctx_ff <= s1_ctx_ff;
   end

   // leading one within each byte
   logic               s3_valid_ff;
   logic [7:0]         s3_nz_ff;
   logic [7:0]         s3_nz_in;
   logic [7:0][3:0]    s3_lead_ff;
   logic [7:0][3:0]    s3_lead_in;
   logic [2:0][63:0]   s3_mag_ff;
   logic [2:0]         s3_neg_ff;
   lav_pkg::ctx_type   s3_ctx_ff;

   always_comb begin
      for (int j = 0; j < 8; j++) begin
         s3_nz_in[j]   = |s2_mx_ff[8*j +: 8];
         s3_lead_in[j] = 4'd0;
         for (int b = 0; b < 8; b++) begin
            if (s2_mx_ff[8*j + b]) begin
               s3_lead_in[j] = 4'(b + 1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_nz_ff   <= s3_nz_in;
      s3_lead_ff <= s3_lead_in;
      s3_mag_ff  <= s2_mag_ff;
      s3_neg_ff  <= s2_neg_ff;
      s3_ctx_ff  <= s2_ctx_ff;
   end

   // bit length of the largest magnitude
   logic               s4_valid_ff;
   logic [6:0]         s4_n_ff;
   logic [6:0]         s4_n_in;
   logic               s4_zero_ff;
   logic [2:0][63:0]   s4_mag_ff;
   logic [2:0]         s4_neg_ff;
   lav_pkg::ctx_type   s4_ctx_ff;

   always_comb begin
      s4_n_in = 7'd0;
      for (int j = 0; j < 8; j++) begin
         if (s3_nz_ff[j]) begin
            s4_n_in = 7'(8 * j) + 7'(s3_lead_ff[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_n_ff    <= s4_n_in;
      s4_zero_ff <= (s3_nz_ff == 8'd0);
      s4_mag_ff  <= s3_mag_ff;
      s4_neg_ff  <= s3_neg_ff;
      s4_ctx_ff  <= s3_ctx_ff;
   end

   // scale so the largest lies in [2^29, 2^30)
   logic               s5_valid_ff;
   logic [2:0][29:0]   s5_sm_ff;
   logic [2:0][29:0]   s5_sm_in;
   logic [2:0]         s5_neg_ff;
   logic               s5_zero_ff;
   lav_pkg::ctx_type   s5_ctx_ff;

   always_comb begin
      logic [63:0] sh;
      sh = 64'd0;
      for (int i = 0; i < 3; i++) begin
         if (s4_n_ff > 7'd30) begin
            sh = s4_mag_ff[i] >> (s4_n_ff - 7'd30);
         end else begin
            sh = s4_mag_ff[i] << (7'd30 - s4_n_ff);
         end
         s5_sm_in[i] = sh[29:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
      s5_sm_ff   <= s5_sm_in;
      s5_neg_ff  <= s4_neg_ff;
      s5_zero_ff <= s4_zero_ff;
      s5_ctx_ff  <= s4_ctx_ff;
   end

   // squares
   logic               s6_valid_ff;
   logic [2:0][59:0]   s6_sq_ff;
   logic [2:0][29:0]   s6_sm_ff;
   logic [2:0]         s6_neg_ff;
   logic               s6_zero_ff;
   lav_pkg::ctx_type   s6_ctx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= s5_valid_ff;
      end
      for (int i = 0; i < 3; i++) begin
         s6_sq_ff[i] <= 60'(s5_sm_ff[i]) * 60'(s5_sm_ff[i]);
      end
      s6_sm_ff   <= s5_sm_ff;
      s6_neg_ff  <= s5_neg_ff;
      s6_zero_ff <= s5_zero_ff;
      s6_ctx_ff  <= s5_ctx_ff;
   end

   // square root, two result bits per stage
   sqrt_type           sq_ff       [0:lav_pkg::SQRT_STAGES];
   logic               sq_valid_ff [0:lav_pkg::SQRT_STAGES];
   lav_pkg::ctx_type   sq_ctx_ff   [0:lav_pkg::SQRT_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff[0] <= 1'b0;
      end else begin
         sq_valid_ff[0] <= s6_valid_ff;
      end
      sq_ff[0].sm   <= s6_sm_ff;
      sq_ff[0].neg  <= s6_neg_ff;
      sq_ff[0].zero <= s6_zero_ff;
      sq_ff[0].v    <= 64'(s6_sq_ff[0]) + 64'(s6_sq_ff[1]) + 64'(s6_sq_ff[2]);
      sq_ff[0].res  <= 64'd0;
      sq_ctx_ff[0]  <= s6_ctx_ff;
   end

   for (genvar k = 0; k < lav_pkg::SQRT_STAGES; k++) begin : g_sqrt
      sqrt_type sq_in;

      always_comb begin
         logic [63:0] bit_w;
         bit_w = 64'd0;
         sq_in = sq_ff[k];
         for (int j = 0; j < lav_pkg::SQRT_STEPS; j++) begin
            bit_w = 64'd1 << (62 - 2 * (lav_pkg::SQRT_STEPS * k + j));
            if (sq_in.v >= sq_in.res + bit_w) begin
               sq_in.v   = sq_in.v - (sq_in.res + bit_w);
               sq_in.res = (sq_in.res >> 1) + bit_w;
            end else begin
               sq_in.res = sq_in.res >> 1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k+1] <= 1'b0;
         end else begin
            sq_valid_ff[k+1] <= sq_valid_ff[k];
         end
         sq_ff[k+1]     <= sq_in;
         sq_ctx_ff[k+1] <= sq_ctx_ff[k];
      end
   end

   // quotient round(m * 2^16 / len), restoring division
   div_type            dv_ff       [0:lav_pkg::DIV_STAGES];
   logic               dv_valid_ff [0:lav_pkg::DIV_STAGES];
   lav_pkg::ctx_type   dv_ctx_ff   [0:lav_pkg::DIV_STAGES];
   logic [30:0]        len_w;

   assign len_w = sq_ff[lav_pkg::SQRT_STAGES].res[30:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else begin
         dv_valid_ff[0] <= sq_valid_ff[lav_pkg::SQRT_STAGES];
      end
      for (int i = 0; i < 3; i++) begin
         dv_ff[0].rem[i] <= (49'(sq_ff[lav_pkg::SQRT_STAGES].sm[i]) << 16)
                            + 49'(len_w >> 1);
         dv_ff[0].q[i]   <= 17'd0;
      end
      dv_ff[0].len  <= len_w;
      dv_ff[0].neg  <= sq_ff[lav_pkg::SQRT_STAGES].neg;
      dv_ff[0].zero <= sq_ff[lav_pkg::SQRT_STAGES].zero;
      dv_ctx_ff[0]  <= sq_ctx_ff[lav_pkg::SQRT_STAGES];
   end

   for (genvar k = 0; k < lav_pkg::DIV_STAGES; k++) begin : g_div
      div_type dv_in;

      always_comb begin
         logic [48:0] d;
         int          b;
         d     = 49'd0;
         b     = 0;
         dv_in = dv_ff[k];
         for (int j = 0; j < lav_pkg::DIV_STEPS; j++) begin
            b = lav_pkg::Q_TOP_BIT - lav_pkg::DIV_STEPS * k - j;
            if (b >= 0) begin
               d = 49'(dv_in.len) << b;
               for (int i = 0; i < 3; i++) begin
                  if (dv_in.rem[i] >= d) begin
                     dv_in.rem[i] = dv_in.rem[i] - d;
                     dv_in.q[i]   = dv_in.q[i] | (17'd1 << b);
                  end
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k+1] <= 1'b0;
         end else begin
            dv_valid_ff[k+1] <= dv_valid_ff[k];
         end
         dv_ff[k+1]     <= dv_in;
         dv_ctx_ff[k+1] <= dv_ctx_ff[k];
      end
   end

   // restore signs; force zero on an all-zero vector
   logic               out_valid_ff;
   lav_pkg::axis_type  out_axis_ff;
   logic               out_zero_ff;
   lav_pkg::ctx_type   out_ctx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= dv_valid_ff[lav_pkg::DIV_STAGES];
      end
      for (int i = 0; i < 3; i++) begin
         if (dv_ff[lav_pkg::DIV_STAGES].zero) begin
            out_axis_ff[i] <= 18'd0;
         end else if (dv_ff[lav_pkg::DIV_STAGES].neg[i]) begin
            out_axis_ff[i] <= 18'd0 - 18'(dv_ff[lav_pkg::DIV_STAGES].q[i]);
         end else begin
            out_axis_ff[i] <= 18'(dv_ff[lav_pkg::DIV_STAGES].q[i]);
         end
      end
      out_zero_ff <= dv_ff[lav_pkg::DIV_STAGES].zero;
      out_ctx_ff  <= dv_ctx_ff[lav_pkg::DIV_STAGES];
   end

   assign out_valid = out_valid_ff;
   assign out_axis  = out_axis_ff;
   assign out_zero  = out_zero_ff;
   assign out_ctx   = out_ctx_ff;

endmodule
`default_nettype wire

// ===== hdl/lav_cross.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lav_cross (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  lav_pkg::vec33_type in_a,
   input  lav_pkg::axis_type  in_b,
   input  lav_pkg::ctx_type   in_ctx,
   output logic               out_valid,
   output lav_pkg::vec64_type out_vec,
   output lav_pkg::ctx_type   out_ctx
);

   logic signed [50:0] p_ff [6];
   logic signed [50:0] p_in [6];
   logic               p_valid_ff;
   lav_pkg::ctx_type   p_ctx_ff;

   always_comb begin
      logic signed [50:0] ax [3];
      logic signed [50:0] bx [3];
      for (int i = 0; i < 3; i++) begin
         ax[i] = 51'($signed(in_a[i]));
         bx[i] = 51'($signed(in_b[i]));
      end
      p_in[0] = ax[1] * bx[2];
      p_in[1] = ax[2] * bx[1];
      p_in[2] = ax[2] * bx[0];
      p_in[3] = ax[0] * bx[2];
      p_in[4] = ax[0] * bx[1];
      p_in[5] = ax[1] * bx[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= in_valid;
      end
      p_ff     <= p_in;
      p_ctx_ff <= in_ctx;
   end

   logic               r_valid_ff;
   lav_pkg::vec64_type r_vec_ff;
   lav_pkg::ctx_type   r_ctx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else begin
         r_valid_ff <= p_valid_ff;
      end
      for (int i = 0; i < 3; i++) begin
         r_vec_ff[i] <= 64'($signed(52'(p_ff[2*i]) - 52'(p_ff[2*i+1])));
      end
      r_ctx_ff <= p_ctx_ff;
   end

   assign out_valid = r_valid_ff;
   assign out_vec   = r_vec_ff;
   assign out_ctx   = r_ctx_ff;

endmodule
`default_nettype wire

// ===== hdl/lav_trans.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lav_trans (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  lav_pkg::ctx_type   in_ctx,
   input  lav_pkg::axis_type  in_up,
   output logic               out_valid,
   output lav_pkg::axes_type  out_axes,
   output lav_pkg::vec32_type out_trans,
   output logic               out_degen
);

   lav_pkg::axes_type  axes_w;

   assign axes_w[0] = in_ctx.right;
   assign axes_w[1] = in_up;
   assign axes_w[2] = in_ctx.fwd;

   // axis times eye, nine products
   logic signed [49:0] m_ff [3][3];
   logic               m_valid_ff;
   lav_pkg::axes_type  m_axes_ff;
   logic               m_degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= in_valid;
      end
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            m_ff[k][i] <= 50'($signed(axes_w[k][i])) * 50'($signed(in_ctx.eye[i]));
         end
      end
      m_axes_ff  <= axes_w;
      m_degen_ff <= in_ctx.degen;
   end

   logic signed [51:0] s_ff [3];
   logic               s_valid_ff;
   lav_pkg::axes_type  s_axes_ff;
   logic               s_degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= m_valid_ff;
      end
      for (int k = 0; k < 3; k++) begin
         s_ff[k] <= 52'(m_ff[k][0]) + 52'(m_ff[k][1]) + 52'(m_ff[k][2]);
      end
      s_axes_ff  <= m_axes_ff;
      s_degen_ff <= m_degen_ff;
   end

   // negate, round half away from zero, saturate
   lav_pkg::vec32_type t_in;

   always_comb begin
      logic [51:0] mag;
      logic [36:0] r;
      mag = 52'd0;
      r   = 37'd0;
      for (int k = 0; k < 3; k++) begin
         mag = s_ff[k][51] ? (52'd0 - s_ff[k]) : s_ff[k];
         r   = 37'((53'(mag) + 53'd32768) >> 16);
         if (!s_ff[k][51] && (s_ff[k] != 52'sd0)) begin
            if (r > 37'h0_8000_0000) begin
               t_in[k] = 32'h8000_0000;
            end else begin
               t_in[k] = 32'd0 - r[31:0];
            end
         end else begin
            if (r > 37'h0_7FFF_FFFF) begin
               t_in[k] = 32'h7FFF_FFFF;
            end else begin
               t_in[k] = r[31:0];
            end
         end
      end
   end

   logic               t_valid_ff;
   lav_pkg::axes_type  t_axes_ff;
   lav_pkg::vec32_type t_trans_ff;
   logic               t_degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff <= 1'b0;
      end else begin
         t_valid_ff <= s_valid_ff;
      end
      t_axes_ff  <= s_axes_ff;
      t_trans_ff <= t_in;
      t_degen_ff <= s_degen_ff;
   end

   assign out_valid = t_valid_ff;
   assign out_axes  = t_axes_ff;
   assign out_trans = t_trans_ff;
   assign out_degen = t_degen_ff;

endmodule
`default_nettype wire

// ===== hdl/look_at_view_matrix.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Left-handed look-at view matrix in Q16.16. An item (eye, target, up hint) is
// taken when start is high and busy low; busy then stays high until the gap
// counter has run down, so the four column results of one item never overlap
// those of the next on the single result port. Each item yields four results
// on consecutive cycles, column 0 to 3, each marked by rsp_valid for one cycle
// and not held: the receiver must take every result as it comes. The path from
// an item to its first column runs through the input register, three
// normalisers in series (31 stages each: shift search, squares, a
// two-bit-per-stage square root and a three-bit-per-stage divider), two cross
// products of two stages, a three-stage translation unit and the column
// register. Up to some 26 items are in flight at once.
module look_at_view_matrix (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lav_pkg::req_type req_item,
   output logic             rsp_valid,
   output lav_pkg::rsp_type rsp_item
);

   logic       accept;
   logic [1:0] gap_ff;
   logic [1:0] gap_in;

   assign accept = start && !busy;
   assign busy   = (gap_ff != 2'd0);

   always_comb begin
      gap_in = gap_ff;
      if (accept) begin
         gap_in = 2'd3;
      end else if (gap_ff != 2'd0) begin
         gap_in = gap_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= 2'd0;
      end else begin
         gap_ff <= gap_in;
      end
   end

   // direction and context
   logic               s0_valid_ff;
   lav_pkg::vec64_type s0_dir_ff;
   lav_pkg::ctx_type   s0_ctx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
      end
      s0_dir_ff[0] <= 64'($signed(33'(req_item.target_x) - 33'(req_item.eye_x)));
      s0_dir_ff[1] <= 64'($signed(33'(req_item.target_y) - 33'(req_item.eye_y)));
      s0_dir_ff[2] <= 64'($signed(33'(req_item.target_z) - 33'(req_item.eye_z)));
      s0_ctx_ff.eye[0]     <= req_item.eye_x;
      s0_ctx_ff.eye[1]     <= req_item.eye_y;
      s0_ctx_ff.eye[2]     <= req_item.eye_z;
      s0_ctx_ff.up_hint[0] <= req_item.up_hint_x;
      s0_ctx_ff.up_hint[1] <= req_item.up_hint_y;
      s0_ctx_ff.up_hint[2] <= req_item.up_hint_z;
      s0_ctx_ff.fwd        <= '0;
      s0_ctx_ff.right      <= '0;
      s0_ctx_ff.degen      <= 1'b0;
   end

   logic               n0_valid;
   lav_pkg::axis_type  n0_axis;
   logic               n0_zero;
   lav_pkg::ctx_type   n0_ctx;
   lav_pkg::ctx_type   c0_ctx_in;
   lav_pkg::vec33_type c0_a;

   lav_norm u_norm_fwd (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_valid_ff),
      .in_vec    (s0_dir_ff),
      .in_ctx    (s0_ctx_ff),
      .out_valid (n0_valid),
      .out_axis  (n0_axis),
      .out_zero  (n0_zero),
      .out_ctx   (n0_ctx)
   );

   always_comb begin
      c0_ctx_in       = n0_ctx;
      c0_ctx_in.fwd   = n0_axis;
      c0_ctx_in.degen = n0_ctx.degen | n0_zero;
      for (int i = 0; i < 3; i++) begin
         c0_a[i] = 33'($signed(n0_ctx.up_hint[i]));
      end
   end

   logic               c0_valid;
   lav_pkg::vec64_type c0_vec;
   lav_pkg::ctx_type   c0_ctx;

   lav_cross u_cross_right (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (n0_valid),
      .in_a      (c0_a),
      .in_b      (n0_axis),
      .in_ctx    (c0_ctx_in),
      .out_valid (c0_valid),
      .out_vec   (c0_vec),
      .out_ctx   (c0_ctx)
   );

   logic               n1_valid;
   lav_pkg::axis_type  n1_axis;
   logic               n1_zero;
   lav_pkg::ctx_type   n1_ctx;
   lav_pkg::ctx_type   c1_ctx_in;
   lav_pkg::vec33_type c1_a;

   lav_norm u_norm_right (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c0_valid),
      .in_vec    (c0_vec),
      .in_ctx    (c0_ctx),
      .out_valid (n1_valid),
      .out_axis  (n1_axis),
      .out_zero  (n1_zero),
      .out_ctx   (n1_ctx)
   );

   always_comb begin
      c1_ctx_in       = n1_ctx;
      c1_ctx_in.right = n1_axis;
      c1_ctx_in.degen = n1_ctx.degen | n1_zero;
      for (int i = 0; i < 3; i++) begin
         c1_a[i] = 33'($signed(n1_ctx.fwd[i]));
      end
   end

   logic               c1_valid;
   lav_pkg::vec64_type c1_vec;
   lav_pkg::ctx_type   c1_ctx;

   lav_cross u_cross_up (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (n1_valid),
      .in_a      (c1_a),
      .in_b      (n1_axis),
      .in_ctx    (c1_ctx_in),
      .out_valid (c1_valid),
      .out_vec   (c1_vec),
      .out_ctx   (c1_ctx)
   );

   logic               n2_valid;
   lav_pkg::axis_type  n2_axis;
   logic               n2_zero;
   lav_pkg::ctx_type   n2_ctx;
   lav_pkg::ctx_type   tr_ctx_in;

   lav_norm u_norm_up (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c1_valid),
      .in_vec    (c1_vec),
      .in_ctx    (c1_ctx),
      .out_valid (n2_valid),
      .out_axis  (n2_axis),
      .out_zero  (n2_zero),
      .out_ctx   (n2_ctx)
   );

   always_comb begin
      tr_ctx_in       = n2_ctx;
      tr_ctx_in.degen = n2_ctx.degen | n2_zero;
   end

   logic               tr_valid;
   lav_pkg::axes_type  tr_axes;
   lav_pkg::vec32_type tr_trans;
   logic               tr_degen;

   lav_trans u_trans (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (n2_valid),
      .in_ctx    (tr_ctx_in),
      .in_up     (n2_axis),
      .out_valid (tr_valid),
      .out_axes  (tr_axes),
      .out_trans (tr_trans),
      .out_degen (tr_degen)
   );

   // hold the finished matrix and step through its columns
   logic               act_ff;
   logic [1:0]         col_ff;
   lav_pkg::axes_type  hold_axes_ff;
   lav_pkg::vec32_type hold_trans_ff;
   logic               hold_degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         col_ff <= lav_pkg::COL_RIGHT;
      end else if (tr_valid) begin
         act_ff <= 1'b1;
         col_ff <= lav_pkg::COL_RIGHT;
      end else if (act_ff) begin
         col_ff <= col_ff + 2'd1;
         if (col_ff == lav_pkg::COL_LAST) begin
            act_ff <= 1'b0;
         end
      end
      if (tr_valid) begin
         hold_axes_ff  <= tr_axes;
         hold_trans_ff <= tr_trans;
         hold_degen_ff <= tr_degen;
      end
   end

   always_comb begin
      rsp_item.column_index = col_ff;
      rsp_item.degenerate   = hold_degen_ff;
      rsp_item.last_column  = (col_ff == lav_pkg::COL_LAST);
      case (col_ff)
         lav_pkg::COL_RIGHT, lav_pkg::COL_UP, lav_pkg::COL_FWD: begin
            rsp_item.entry_row0 = 32'($signed(hold_axes_ff[col_ff][0]));
            rsp_item.entry_row1 = 32'($signed(hold_axes_ff[col_ff][1]));
            rsp_item.entry_row2 = 32'($signed(hold_axes_ff[col_ff][2]));
            rsp_item.entry_row3 = hold_trans_ff[col_ff];
         end
         default: begin
            rsp_item.entry_row0 = 32'sd0;
            rsp_item.entry_row1 = 32'sd0;
            rsp_item.entry_row2 = 32'sd0;
            rsp_item.entry_row3 = lav_pkg::ONE_Q16;
         end
      endcase
   end

   assign rsp_valid = act_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("item taken while the previous one still owns the result port");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      tr_valid |-> (!act_ff || (col_ff == lav_pkg::COL_LAST)))
      else $error("finished matrix arrived while columns were still being sent");

   a_column_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.last_column) |=>
      (rsp_valid && (rsp_item.column_index == $past(rsp_item.column_index) + 2'd1)))
      else $error("column results not sent on consecutive cycles in order");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   lav_pkg::req_type req_item;
   logic             rsp_valid;
   lav_pkg::rsp_type rsp_item;

   look_at_view_matrix dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   lav_pkg::req_type pending_cameras[$];
   int               pending_gaps[$];
   lav_pkg::rsp_type expected_columns[$];
   int               errors;
   int               cycles;
   int               cameras_sent;
   int               columns_seen;
   int               degenerate_seen;
   bit               stimulus_done;
   bit               hold_for_drain;
   bit               item_taken;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res;
      longint unsigned bitpos;
      res = 0;
      bitpos = 64'd1 << 62;
      while (bitpos > v) bitpos >>= 2;
      while (bitpos != 0) begin
         if (v >= res + bitpos) begin
            v -= res + bitpos;
            res = (res >> 1) + bitpos;
         end else begin
            res >>= 1;
         end
         bitpos >>= 2;
      end
      return res;
   endfunction

   // Returns 1 when the vector is all zero.
   function automatic bit unit_vector(input longint v[3], output longint u[3]);
      longint unsigned m[3];
      longint unsigned peak, sum, len, q;
      int n;
      peak = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = magnitude(v[i]);
         if (m[i] > peak) peak = m[i];
      end
      if (peak == 0) begin
         for (int i = 0; i < 3; i++) u[i] = 0;
         return 1'b1;
      end
      n = 0;
      while (peak != 0) begin
         n++;
         peak >>= 1;
      end
      for (int i = 0; i < 3; i++) begin
         if (n > 30) m[i] >>= (n - 30);
         else m[i] <<= (30 - n);
         sum += m[i] * m[i];
      end
      len = root_floor(sum);
      for (int i = 0; i < 3; i++) begin
         q = (m[i] * 64'd65536 + (len >> 1)) / len;
         u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
      return 1'b0;
   endfunction

   function automatic void cross_product(input longint a[3], input longint b[3],
                                         output longint r[3]);
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   function automatic logic [31:0] translation(longint a[3], longint e[3]);
      longint s;
      longint unsigned r;
      s = a[0] * e[0] + a[1] * e[1] + a[2] * e[2];
      r = (magnitude(s) + 64'd32768) >> 16;
      if (s > 0) begin
         if (r > 64'h8000_0000) return 32'h8000_0000;
         return 32'(-longint'(r));
      end
      if (r > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
      return 32'(r);
   endfunction

   function automatic void predict_view_matrix(lav_pkg::req_type c);
      longint eye[3], hint[3], dir[3], fwd[3], rraw[3], rgt[3], uraw[3], upv[3];
      longint ax[3];
      bit degen;
      lav_pkg::rsp_type col;
      logic [1:0] cols[3];
      eye[0] = c.eye_x;
      eye[1] = c.eye_y;
      eye[2] = c.eye_z;
      dir[0] = longint'(c.target_x) - eye[0];
      dir[1] = longint'(c.target_y) - eye[1];
      dir[2] = longint'(c.target_z) - eye[2];
      hint[0] = c.up_hint_x;
      hint[1] = c.up_hint_y;
      hint[2] = c.up_hint_z;
      degen = unit_vector(dir, fwd);
      cross_product(hint, fwd, rraw);
      degen |= unit_vector(rraw, rgt);
      cross_product(fwd, rgt, uraw);
      degen |= unit_vector(uraw, upv);
      cols[0] = lav_pkg::COL_RIGHT;
      cols[1] = lav_pkg::COL_UP;
      cols[2] = lav_pkg::COL_FWD;
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++)
            ax[i] = (k == 0) ? rgt[i] : (k == 1) ? upv[i] : fwd[i];
         col.column_index = cols[k];
         col.entry_row0 = 32'(ax[0]);
         col.entry_row1 = 32'(ax[1]);
         col.entry_row2 = 32'(ax[2]);
         col.entry_row3 = translation(ax, eye);
         col.degenerate = degen;
         col.last_column = 1'b0;
         expected_columns.push_back(col);
      end
      col = '0;
      col.column_index = lav_pkg::COL_LAST;
      col.entry_row3 = lav_pkg::ONE_Q16;
      col.degenerate = degen;
      col.last_column = 1'b1;
      expected_columns.push_back(col);
   endfunction

   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
         2: return 32'($signed($urandom_range(0, 64)) - 32);
         default: begin
            case ($urandom_range(0, 5))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0;
               3: return lav_pkg::ONE_Q16;
               4: return 32'hFFFF_0000;
               default: return 32'h1;
            endcase
         end
      endcase
   endfunction

   task automatic queue_camera(lav_pkg::req_type c);
      pending_cameras.push_back(c);
      pending_gaps.push_back(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
   endtask

   initial begin
      lav_pkg::req_type c;
      logic [31:0] edge_vals[6];
      edge_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, lav_pkg::ONE_Q16,
                    32'hFFFF_0000, 32'h1};
      // standard camera looking down +z with y up
      c = '0;
      c.target_z = lav_pkg::ONE_Q16;
      c.up_hint_y = lav_pkg::ONE_Q16;
      queue_camera(c);
      // target equal to eye: zero forward axis
      c = '0;
      c.eye_x = 32'h0003_0000;
      c.target_x = 32'h0003_0000;
      c.up_hint_y = lav_pkg::ONE_Q16;
      queue_camera(c);
      // up hint parallel to forward: zero right axis
      c = '0;
      c.target_y = 32'h0005_0000;
      c.up_hint_y = lav_pkg::ONE_Q16;
      queue_camera(c);
      // zero up hint
      c = '0;
      c.target_x = lav_pkg::ONE_Q16;
      queue_camera(c);
      // extreme span and saturating translations
      c = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h0};
      queue_camera(c);
      c = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h1};
      queue_camera(c);
      c = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
            32'h0, 32'h0, 32'h7FFF_FFFF};
      queue_camera(c);
      // tiny direction and tiny hint
      c = '0;
      c.target_z = 32'h1;
      c.up_hint_x = 32'hFFFF_FFFF;
      queue_camera(c);
      for (int k = 0; k < 12; k++) begin
         c.eye_x = edge_vals[$urandom_range(0, 5)];
         c.eye_y = edge_vals[$urandom_range(0, 5)];
         c.eye_z = edge_vals[$urandom_range(0, 5)];
         c.target_x = edge_vals[$urandom_range(0, 5)];
         c.target_y = edge_vals[$urandom_range(0, 5)];
         c.target_z = edge_vals[$urandom_range(0, 5)];
         c.up_hint_x = edge_vals[$urandom_range(0, 5)];
         c.up_hint_y = edge_vals[$urandom_range(0, 5)];
         c.up_hint_z = edge_vals[$urandom_range(0, 5)];
         queue_camera(c);
      end
      for (int k = 0; k < 250; k++) begin
         int mode;
         mode = $urandom_range(0, 3);
         c.eye_x = rand_coord(mode);
         c.eye_y = rand_coord(mode);
         c.eye_z = rand_coord(mode);
         c.target_x = rand_coord($urandom_range(0, 3));
         c.target_y = rand_coord($urandom_range(0, 3));
         c.target_z = rand_coord($urandom_range(0, 3));
         c.up_hint_x = rand_coord($urandom_range(0, 3));
         c.up_hint_y = rand_coord($urandom_range(0, 3));
         c.up_hint_z = rand_coord($urandom_range(0, 3));
         if ($urandom_range(0, 15) == 0) begin
            c.target_x = c.eye_x;
            c.target_y = c.eye_y;
            c.target_z = c.eye_z;
         end
         queue_camera(c);
      end
   end

   // driver
   int  gap_left;
   bit  have_gap;
   bit  drained_once;
   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      gap_left = 0;
      have_gap = 1'b0;
      drained_once = 1'b0;
      stimulus_done = 1'b0;
      hold_for_drain = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // note whether the last rising edge took an item
   always @(posedge clock) begin
      item_taken = !reset && start && !busy;
   end

   always @(negedge clock) begin
      if (!reset) begin
         // drop the item just taken
         if (start && item_taken) begin
            start <= 1'b0;
            cameras_sent++;
            if (cameras_sent == 140 && !drained_once) hold_for_drain <= 1'b1;
         end else if (start) begin
            // hold while busy
         end else if (hold_for_drain) begin
            if (expected_columns.size() == 0) begin
               hold_for_drain <= 1'b0;
               drained_once <= 1'b1;
            end
         end else if (pending_cameras.size() == 0) begin
            stimulus_done <= 1'b1;
         end else if (!have_gap) begin
            gap_left = pending_gaps.pop_front();
            have_gap = 1'b1;
         end
         if (have_gap && !start && !hold_for_drain) begin
            if (gap_left > 0) begin
               gap_left--;
            end else begin
               req_item <= pending_cameras[0];
               predict_view_matrix(pending_cameras.pop_front());
               start <= 1'b1;
               have_gap = 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      lav_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         columns_seen++;
         if (rsp_item.degenerate) degenerate_seen++;
         if (expected_columns.size() == 0) begin
            errors++;
            $display("%0t: unexpected column, actual %p", $time, rsp_item);
         end else begin
            want = expected_columns.pop_front();
            if (rsp_item.column_index !== want.column_index ||
                rsp_item.entry_row0 !== want.entry_row0 ||
                rsp_item.entry_row1 !== want.entry_row1 ||
                rsp_item.entry_row2 !== want.entry_row2 ||
                rsp_item.entry_row3 !== want.entry_row3 ||
                rsp_item.degenerate !== want.degenerate ||
                rsp_item.last_column !== want.last_column) begin
               errors++;
               $display("%0t: column mismatch, expected %p, actual %p",
                        $time, want, rsp_item);
            end
         end
      end
   end

   initial begin
      errors = 0;
      cycles = 0;
      cameras_sent = 0;
      columns_seen = 0;
      degenerate_seen = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > 200000) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      wait (stimulus_done && expected_columns.size() == 0);
      repeat (150) @(posedge clock);
      $display("Ran %0d cameras through the view matrix, %0d columns checked,",
               cameras_sent, columns_seen);
      $display("%0d of them flagged degenerate; %0d mismatches.", degenerate_seen, errors);
      if (errors == 0 && expected_columns.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== look_at_view_matrix.f =====
hdl/lav_pkg.sv
hdl/lav_norm.sv
hdl/lav_cross.sv
hdl/lav_trans.sv
hdl/look_at_view_matrix.sv
tb/testbench.sv
